// File: design/thc_pkg.sv
// shared constants and register codes for the temperature and humidity compensation block
package thc_pkg;

   // configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // register indexes, in port order
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_CAL_1       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_CAL_2       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_CAL_3       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_CAL_1        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_CAL_2        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_CAL_3        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_CAL_45_BYTES = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_CAL_6        = 3'd7;

   // stream widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // pipeline depth
   localparam int STAGES = 12;

   // compensation constants
   localparam logic signed [31:0] TEMP_MIN   = -32'sd4000;
   localparam logic signed [31:0] TEMP_MAX   = 32'sd8500;
   localparam logic signed [31:0] TEMP_RND   = 32'sd128;
   localparam logic signed [31:0] FINE_OFS   = 32'sd76800;
   localparam logic signed [31:0] P_RND      = 32'sd16384;
   localparam logic signed [31:0] R_OFS      = 32'sd32768;
   localparam logic signed [31:0] S_OFS      = 32'sd2097152;
   localparam logic signed [31:0] G_RND      = 32'sd8192;
   localparam logic signed [31:0] HUM_MAX    = 32'sd419430400;
   localparam logic [16:0]        HUM_Q10_MAX = 17'd102400;

   // divide by 100 through a reciprocal, exact for magnitudes up to 8500
   localparam logic [26:0] RECIP_100   = 27'd5243;
   localparam int          RECIP_SHIFT = 19;

endpackage

// File: design/temp_humidity_compensation.sv
// top level: pipelined temperature and humidity compensation with apb calibration registers
//
// channel   direction  transaction fields
// req_*     in         temp_raw, hum_raw
// rsp_*     out        temp_centi, temp_whole, hum_q10, hum_whole
// csr_*     in/out     eight calibration registers at byte address 4*index
//
// twelve register stages, one multiply level per stage at most
// one transaction per cycle is accepted when the pipe can move
// each stage holds its item while the next one is full and stalled, bubbles collapse
// req_tready is low only when every stage holds an item and rsp_tready is low
// reset clears the valid bits and the calibration registers, data registers are not reset
module temp_humidity_compensation (
   input  logic                               clock,
   input  logic                               reset,
   // temp_raw [19:0], hum_raw [35:20], zero fill above
   input  logic [thc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // temp_centi [14:0], temp_whole [22:15], hum_q10 [39:23], hum_whole [46:40], zero fill
   output logic [thc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [thc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [thc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [thc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int N = thc_pkg::STAGES;

   // ---------------------------------------------------------------
   // calibration registers
   // ---------------------------------------------------------------
   logic [15:0] cal_t1_ff;
   logic [15:0] cal_t2_ff;
   logic [15:0] cal_t3_ff;
   logic [7:0]  cal_h1_ff;
   logic [15:0] cal_h2_ff;
   logic [7:0]  cal_h3_ff;
   logic [23:0] cal_h45_ff;
   logic [7:0]  cal_h6_ff;

   logic                           csr_we;
   logic [thc_pkg::CSR_IDX_W-1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[thc_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t1_ff  <= '0;
         cal_t2_ff  <= '0;
         cal_t3_ff  <= '0;
         cal_h1_ff  <= '0;
         cal_h2_ff  <= '0;
         cal_h3_ff  <= '0;
         cal_h45_ff <= '0;
         cal_h6_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            thc_pkg::REG_TEMP_CAL_1:       cal_t1_ff  <= csr_pwdata[15:0];
            thc_pkg::REG_TEMP_CAL_2:       cal_t2_ff  <= csr_pwdata[15:0];
            thc_pkg::REG_TEMP_CAL_3:       cal_t3_ff  <= csr_pwdata[15:0];
            thc_pkg::REG_HUM_CAL_1:        cal_h1_ff  <= csr_pwdata[7:0];
            thc_pkg::REG_HUM_CAL_2:        cal_h2_ff  <= csr_pwdata[15:0];
            thc_pkg::REG_HUM_CAL_3:        cal_h3_ff  <= csr_pwdata[7:0];
            thc_pkg::REG_HUM_CAL_45_BYTES: cal_h45_ff <= csr_pwdata[23:0];
            thc_pkg::REG_HUM_CAL_6:        cal_h6_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read mux, zero extended
   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         thc_pkg::REG_TEMP_CAL_1:       csr_prdata = {16'd0, cal_t1_ff};
         thc_pkg::REG_TEMP_CAL_2:       csr_prdata = {16'd0, cal_t2_ff};
         thc_pkg::REG_TEMP_CAL_3:       csr_prdata = {16'd0, cal_t3_ff};
         thc_pkg::REG_HUM_CAL_1:        csr_prdata = {24'd0, cal_h1_ff};
         thc_pkg::REG_HUM_CAL_2:        csr_prdata = {16'd0, cal_h2_ff};
         thc_pkg::REG_HUM_CAL_3:        csr_prdata = {24'd0, cal_h3_ff};
         thc_pkg::REG_HUM_CAL_45_BYTES: csr_prdata = {8'd0, cal_h45_ff};
         thc_pkg::REG_HUM_CAL_6:        csr_prdata = {24'd0, cal_h6_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   // calibration words widened to 32-bit two's complement
   logic signed [31:0] t1_x, t2_x, t3_x, h1_x, h2_x, h3_x, h4_x, h5_x, h6_x;

   assign t1_x = {16'd0, cal_t1_ff};
   assign t2_x = {{16{cal_t2_ff[15]}}, cal_t2_ff};
   assign t3_x = {{16{cal_t3_ff[15]}}, cal_t3_ff};
   assign h1_x = {24'd0, cal_h1_ff};
   assign h2_x = {{16{cal_h2_ff[15]}}, cal_h2_ff};
   assign h3_x = {24'd0, cal_h3_ff};
   // word four: first byte signed, low nibble of second byte below it
   assign h4_x = {{20{cal_h45_ff[7]}}, cal_h45_ff[7:0], cal_h45_ff[11:8]};
   // word five: third byte signed, high nibble of second byte below it
   assign h5_x = {{20{cal_h45_ff[23]}}, cal_h45_ff[23:16], cal_h45_ff[15:12]};
   assign h6_x = {{24{cal_h6_ff[7]}}, cal_h6_ff};

   // ---------------------------------------------------------------
   // pipeline flow control
   // ---------------------------------------------------------------
   logic [N:1]   vld_ff;
   logic [N+1:1] adv;

   assign adv[N+1] = rsp_tready;

   for (genvar k = 1; k <= N; k++) begin : g_adv
      // a stage loads when it is empty or its item moves on
      assign adv[k] = ~vld_ff[k] | adv[k+1];
   end

   assign req_tready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) begin
            vld_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= N; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 1: differences against temperature word one
   // ---------------------------------------------------------------
   logic [19:0]        in_temp;
   logic [15:0]        in_hum;
   logic signed [31:0] s1_a_in, s1_b_in, s1_adc_t3, s1_adc_t4, s1_t1_2;
   logic signed [31:0] s1_a_ff, s1_b_ff;
   logic [15:0]        s1_hr_ff;

   assign in_temp   = req_tdata[19:0];
   assign in_hum    = req_tdata[35:20];
   assign s1_adc_t3 = {15'd0, in_temp[19:3]};
   assign s1_adc_t4 = {16'd0, in_temp[19:4]};
   assign s1_t1_2   = {15'd0, cal_t1_ff, 1'b0};
   assign s1_a_in   = s1_adc_t3 - s1_t1_2;
   assign s1_b_in   = s1_adc_t4 - t1_x;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_a_ff  <= s1_a_in;
         s1_b_ff  <= s1_b_in;
         s1_hr_ff <= in_hum;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: linear term and square of the difference
   // ---------------------------------------------------------------
   logic signed [31:0] s2_prod_a, s2_prod_b;
   logic signed [31:0] s2_var1_ff, s2_bb_ff;
   logic [15:0]        s2_hr_ff;

   assign s2_prod_a = s1_a_ff * t2_x;
   assign s2_prod_b = s1_b_ff * s1_b_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_var1_ff <= s2_prod_a >>> 11;
         s2_bb_ff   <= s2_prod_b >>> 12;
         s2_hr_ff   <= s1_hr_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: square term
   // ---------------------------------------------------------------
   logic signed [31:0] s3_prod;
   logic signed [31:0] s3_var1_ff, s3_var2_ff;
   logic [15:0]        s3_hr_ff;

   assign s3_prod = s2_bb_ff * t3_x;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_var1_ff <= s2_var1_ff;
         s3_var2_ff <= s3_prod >>> 14;
         s3_hr_ff   <= s2_hr_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: fine temperature
   // ---------------------------------------------------------------
   logic signed [31:0] s4_fine_in, s4_fine_ff;
   logic [15:0]        s4_hr_ff;

   assign s4_fine_in = s3_var1_ff + s3_var2_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_fine_ff <= s4_fine_in;
         s4_hr_ff   <= s3_hr_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: centidegrees with saturation, humidity offset of fine value
   // ---------------------------------------------------------------
   logic signed [31:0] s5_tsum, s5_tc;
   logic signed [14:0] s5_tcl_in;
   logic signed [31:0] s5_v_in;
   logic signed [14:0] s5_tcl_ff;
   logic signed [31:0] s5_v_ff;
   logic [15:0]        s5_hr_ff;

   // fine * 5 as shift and add
   assign s5_tsum = (s4_fine_ff <<< 2) + s4_fine_ff + thc_pkg::TEMP_RND;
   assign s5_tc   = s5_tsum >>> 8;
   assign s5_v_in = s4_fine_ff - thc_pkg::FINE_OFS;

   always_comb begin
      priority if (s5_tc < thc_pkg::TEMP_MIN) begin
         s5_tcl_in = thc_pkg::TEMP_MIN[14:0];
      end else if (s5_tc > thc_pkg::TEMP_MAX) begin
         s5_tcl_in = thc_pkg::TEMP_MAX[14:0];
      end else begin
         s5_tcl_in = s5_tc[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_tcl_ff <= s5_tcl_in;
         s5_v_ff   <= s5_v_in;
         s5_hr_ff  <= s4_hr_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 6: products on the fine offset, magnitude / 100 for whole degrees
   // ---------------------------------------------------------------
   logic signed [31:0] s6_prod_h5, s6_prod_h6, s6_prod_h3, s6_r_sh;
   logic [14:0]        s6_tneg_val;
   logic [13:0]        s6_tmag;
   logic [26:0]        s6_tprod;
   logic signed [31:0] s6_h5v_ff, s6_q_ff, s6_r_ff;
   logic signed [14:0] s6_tcl_ff;
   logic [7:0]         s6_tq_ff;
   logic               s6_tneg_ff;
   logic [15:0]        s6_hr_ff;

   assign s6_prod_h5  = h5_x * s5_v_ff;
   assign s6_prod_h6  = s5_v_ff * h6_x;
   assign s6_prod_h3  = s5_v_ff * h3_x;
   assign s6_r_sh     = s6_prod_h3 >>> 11;
   assign s6_tneg_val = -s5_tcl_ff;
   assign s6_tmag     = s5_tcl_ff[14] ? s6_tneg_val[13:0] : s5_tcl_ff[13:0];
   assign s6_tprod    = {13'd0, s6_tmag} * thc_pkg::RECIP_100;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_h5v_ff  <= s6_prod_h5;
         s6_q_ff    <= s6_prod_h6 >>> 10;
         s6_r_ff    <= s6_r_sh + thc_pkg::R_OFS;
         s6_tcl_ff  <= s5_tcl_ff;
         s6_tq_ff   <= s6_tprod[thc_pkg::RECIP_SHIFT +: 8];
         s6_tneg_ff <= s5_tcl_ff[14];
         s6_hr_ff   <= s5_hr_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 7: humidity base term and gain factor, signed whole degrees
   // ---------------------------------------------------------------
   logic signed [31:0] s7_hr_x, s7_h4_sh, s7_num, s7_prod_qr, s7_qr_sh;
   logic [7:0]         s7_tw_in;
   logic signed [31:0] s7_p_ff, s7_s_ff;
   logic signed [14:0] s7_tcl_ff;
   logic [7:0]         s7_tw_ff;

   assign s7_hr_x    = {2'd0, s6_hr_ff, 14'd0};
   assign s7_h4_sh   = h4_x <<< 20;
   assign s7_num     = s7_hr_x - s7_h4_sh - s6_h5v_ff + thc_pkg::P_RND;
   assign s7_prod_qr = s6_q_ff * s6_r_ff;
   assign s7_qr_sh   = s7_prod_qr >>> 10;
   assign s7_tw_in   = s6_tneg_ff ? (8'd0 - s6_tq_ff) : s6_tq_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_p_ff   <= s7_num >>> 15;
         s7_s_ff   <= s7_qr_sh + thc_pkg::S_OFS;
         s7_tcl_ff <= s6_tcl_ff;
         s7_tw_ff  <= s7_tw_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 8: overall humidity gain
   // ---------------------------------------------------------------
   logic signed [31:0] s8_prod, s8_sum;
   logic signed [31:0] s8_p_ff, s8_g_ff;
   logic signed [14:0] s8_tcl_ff;
   logic [7:0]         s8_tw_ff;

   assign s8_prod = s7_s_ff * h2_x;
   assign s8_sum  = s8_prod + thc_pkg::G_RND;

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_p_ff   <= s7_p_ff;
         s8_g_ff   <= s8_sum >>> 14;
         s8_tcl_ff <= s7_tcl_ff;
         s8_tw_ff  <= s7_tw_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 9: humidity accumulator
   // ---------------------------------------------------------------
   logic signed [31:0] s9_v_in, s9_v_ff;
   logic signed [14:0] s9_tcl_ff;
   logic [7:0]         s9_tw_ff;

   assign s9_v_in = s8_p_ff * s8_g_ff;

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s9_v_ff   <= s9_v_in;
         s9_tcl_ff <= s8_tcl_ff;
         s9_tw_ff  <= s8_tw_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 10: square of the scaled accumulator
   // ---------------------------------------------------------------
   logic signed [31:0] s10_w, s10_prod;
   logic signed [31:0] s10_v_ff, s10_x_ff;
   logic signed [14:0] s10_tcl_ff;
   logic [7:0]         s10_tw_ff;

   assign s10_w    = s9_v_ff >>> 15;
   assign s10_prod = s10_w * s10_w;

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         s10_v_ff   <= s9_v_ff;
         s10_x_ff   <= s10_prod >>> 7;
         s10_tcl_ff <= s9_tcl_ff;
         s10_tw_ff  <= s9_tw_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 11: square correction
   // ---------------------------------------------------------------
   logic signed [31:0] s11_prod;
   logic signed [31:0] s11_v_ff, s11_y_ff;
   logic signed [14:0] s11_tcl_ff;
   logic [7:0]         s11_tw_ff;

   assign s11_prod = s10_x_ff * h1_x;

   always_ff @(posedge clock) begin
      if (adv[11]) begin
         s11_v_ff   <= s10_v_ff;
         s11_y_ff   <= s11_prod >>> 4;
         s11_tcl_ff <= s10_tcl_ff;
         s11_tw_ff  <= s10_tw_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 12: clamp to 0..100 percent, scale, output register
   // ---------------------------------------------------------------
   logic signed [31:0] s12_hum, s12_hcl;
   logic [16:0]        s12_hq_in;
   logic [16:0]        s12_hq_ff;
   logic [6:0]         s12_hw_ff;
   logic signed [14:0] s12_tcl_ff;
   logic [7:0]         s12_tw_ff;

   assign s12_hum = s11_v_ff - s11_y_ff;

   always_comb begin
      priority if (s12_hum < 32'sd0) begin
         s12_hcl = 32'sd0;
      end else if (s12_hum > thc_pkg::HUM_MAX) begin
         s12_hcl = thc_pkg::HUM_MAX;
      end else begin
         s12_hcl = s12_hum;
      end
   end

   // clamped value stays below 2^29, so bits 28:12 hold the whole quotient
   assign s12_hq_in = s12_hcl[28:12];

   always_ff @(posedge clock) begin
      if (adv[12]) begin
         s12_hq_ff  <= s12_hq_in;
         s12_hw_ff  <= s12_hq_in[16:10];
         s12_tcl_ff <= s11_tcl_ff;
         s12_tw_ff  <= s11_tw_ff;
      end
   end

   assign rsp_tvalid = vld_ff[N];
   assign rsp_tdata  = {1'b0, s12_hw_ff, s12_hq_ff, s12_tw_ff, s12_tcl_ff};

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // the input side stalls only when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&vld_ff))
      else $error("input stalled with an empty stage");

   // an accepted transaction lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[1])
      else $error("accepted transaction lost at entry");

   // humidity result within range and whole percent consistent
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (s12_hq_ff <= thc_pkg::HUM_Q10_MAX) && (s12_hw_ff == s12_hq_ff[16:10]))
      else $error("humidity result out of range");

   // temperature result within the saturation limits
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (s12_tcl_ff >= 15'sd0 - 15'sd4000) && (s12_tcl_ff <= 15'sd8500))
      else $error("temperature result out of range");

endmodule

// File: tb/thc_tb_pkg.sv
// calibration and reading types plus the scoreboard that predicts and checks compensated readings
package thc_tb_pkg;

   typedef struct packed {
      bit [15:0] temp_cal_1;
      bit [15:0] temp_cal_2;
      bit [15:0] temp_cal_3;
      bit [7:0]  hum_cal_1;
      bit [15:0] hum_cal_2;
      bit [7:0]  hum_cal_3;
      bit [23:0] hum_cal_45_bytes;
      bit [7:0]  hum_cal_6;
   } thc_cal_type;

   // field order matches rsp_tdata from the top bit down: temp_centi sits lowest
   typedef struct packed {
      bit [6:0]  hum_whole;
      bit [16:0] hum_q10;
      bit [7:0]  temp_whole;
      bit [14:0] temp_centi;
   } thc_reading_type;

   localparam int CENTI_LO = -4000;
   localparam int CENTI_HI = 8500;
   localparam int HUM_ACC_HI = 419430400;

   class thc_scoreboard;
      thc_cal_type     cal;
      thc_reading_type pending_readings[$];
      int unsigned     failures;

      static function bit [31:0] asr(bit [31:0] x, int n);
         return $unsigned($signed(x) >>> n);
      endfunction

      // 32-bit integer compensation, everything wraps modulo 2^32
      function thc_reading_type compensate(bit [19:0] temp_raw, bit [15:0] hum_raw);
         bit [31:0] adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
         bit [31:0] a, b, var1, var2, fine, tc, v, p, q, r, s, g, w;
         bit [7:0] b0, b1, b2;
         int temp_c, hum, temp_deg, hum_pct;
         thc_reading_type res;
         adc_t = 32'(temp_raw);
         adc_h = 32'(hum_raw);
         t1 = 32'(cal.temp_cal_1);
         t2 = {{16{cal.temp_cal_2[15]}}, cal.temp_cal_2};
         t3 = {{16{cal.temp_cal_3[15]}}, cal.temp_cal_3};
         h1 = 32'(cal.hum_cal_1);
         h2 = {{16{cal.hum_cal_2[15]}}, cal.hum_cal_2};
         h3 = 32'(cal.hum_cal_3);
         b0 = cal.hum_cal_45_bytes[7:0];
         b1 = cal.hum_cal_45_bytes[15:8];
         b2 = cal.hum_cal_45_bytes[23:16];
         h4 = {{20{b0[7]}}, b0, b1[3:0]};
         h5 = {{20{b2[7]}}, b2, b1[7:4]};
         h6 = {{24{cal.hum_cal_6[7]}}, cal.hum_cal_6};

         a    = (adc_t >> 3) - (t1 << 1);
         var1 = asr(a * t2, 11);
         b    = (adc_t >> 4) - t1;
         var2 = asr(asr(b * b, 12) * t3, 14);
         fine = var1 + var2;
         tc   = asr(fine * 32'd5 + 32'd128, 8);
         temp_c = int'(tc);
         if (temp_c < CENTI_LO) temp_c = CENTI_LO;
         if (temp_c > CENTI_HI) temp_c = CENTI_HI;

         v = fine - 32'd76800;
         p = asr((adc_h << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
         q = asr(v * h6, 10);
         r = asr(v * h3, 11) + 32'd32768;
         s = asr(q * r, 10) + 32'd2097152;
         g = asr(s * h2 + 32'd8192, 14);
         v = p * g;
         w = asr(v, 15);
         v = v - asr(asr(w * w, 7) * h1, 4);
         hum = int'(v);
         if (hum < 0) hum = 0;
         if (hum > HUM_ACC_HI) hum = HUM_ACC_HI;
         hum = hum >>> 12;

         temp_deg = temp_c / 100;
         hum_pct  = hum / 1024;
         res.temp_centi = temp_c[14:0];
         res.temp_whole = temp_deg[7:0];
         res.hum_q10    = hum[16:0];
         res.hum_whole  = hum_pct[6:0];
         return res;
      endfunction

      function void note_sample(bit [19:0] temp_raw, bit [15:0] hum_raw);
         pending_readings.push_back(compensate(temp_raw, hum_raw));
      endfunction

      function void check_reading(logic [47:0] data);
         thc_reading_type got, want;
         if (pending_readings.size() == 0) begin
            $error("result transaction with nothing expected: %h", data);
            failures++;
            return;
         end
         want = pending_readings.pop_front();
         if ($isunknown(data[46:0])) begin
            $error("result data unknown: %h", data);
            failures++;
            return;
         end
         got = data[46:0];
         if (got.temp_centi != want.temp_centi) begin
            $error("temp_centi: expected %0d, got %0d",
                   $signed(want.temp_centi), $signed(got.temp_centi));
            failures++;
         end
         if (got.temp_whole != want.temp_whole) begin
            $error("temp_whole: expected %0d, got %0d",
                   $signed(want.temp_whole), $signed(got.temp_whole));
            failures++;
         end
         if (got.hum_q10 != want.hum_q10) begin
            $error("hum_q10: expected %0d, got %0d", want.hum_q10, got.hum_q10);
            failures++;
         end
         if (got.hum_whole != want.hum_whole) begin
            $error("hum_whole: expected %0d, got %0d", want.hum_whole, got.hum_whole);
            failures++;
         end
      endfunction

      function int pending();
         return pending_readings.size();
      endfunction
   endclass

endpackage

// File: tb/tb_top.sv
// top of the testbench: drives readings and calibration writes, checks compensated results
module tb_top;

   // random readings per calibration phase, seven phases give about 1550 in total
   localparam int PHASES      = 7;
   localparam int RAND_ITEMS  = 222;
   localparam int TOTAL_RAND  = PHASES * RAND_ITEMS;

   logic                           clock;
   logic                           reset;
   logic [thc_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [thc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [thc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [thc_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [thc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // idle percentages for the sender and the receiver, changed as the run goes on
   int send_idle_pct = 0;
   int stall_pct     = 0;

   thc_tb_pkg::thc_scoreboard sb = new;

   temp_humidity_compensation uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #400000;
      $display("temp_humidity_compensation verification failed");
      $finish;
   end

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // both channels sampled at the rising edge, the input side first so the
   // expectation is queued before any result is compared
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata[19:0], req_tdata[35:20]);
         if (rsp_tvalid && rsp_tready) sb.check_reading(rsp_tdata);
      end
   end

   // one reading transaction, with random idle cycles in front of it
   task automatic send_sample(input bit [19:0] temp_raw, input bit [15:0] hum_raw);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, hum_raw, temp_raw};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait until every expected result is in
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // apb write: setup then access, junk above the register width must be dropped
   task automatic csr_write(input logic [thc_pkg::CSR_IDX_W-1:0] idx, input int width,
                            input bit [31:0] value);
      bit [31:0] junk;
      junk = $urandom;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= (junk << width) | value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // apb read, only the bits within the register width are compared
   task automatic csr_check(input logic [thc_pkg::CSR_IDX_W-1:0] idx, input int width,
                            input bit [31:0] value, input string name);
      logic [31:0] mask;
      mask = (32'd1 << width) - 32'd1;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== (value & mask)) begin
         $error("%s readback: expected %h, got %h", name, value & mask, csr_prdata & mask);
         sb.failures++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write a full calibration set, read it back, then hand it to the predictor
   task automatic apply_cal(input thc_tb_pkg::thc_cal_type c);
      csr_write(thc_pkg::REG_TEMP_CAL_1,       16, 32'(c.temp_cal_1));
      csr_write(thc_pkg::REG_TEMP_CAL_2,       16, 32'(c.temp_cal_2));
      csr_write(thc_pkg::REG_TEMP_CAL_3,       16, 32'(c.temp_cal_3));
      csr_write(thc_pkg::REG_HUM_CAL_1,         8, 32'(c.hum_cal_1));
      csr_write(thc_pkg::REG_HUM_CAL_2,        16, 32'(c.hum_cal_2));
      csr_write(thc_pkg::REG_HUM_CAL_3,         8, 32'(c.hum_cal_3));
      csr_write(thc_pkg::REG_HUM_CAL_45_BYTES, 24, 32'(c.hum_cal_45_bytes));
      csr_write(thc_pkg::REG_HUM_CAL_6,         8, 32'(c.hum_cal_6));
      csr_check(thc_pkg::REG_TEMP_CAL_1,       16, 32'(c.temp_cal_1),       "temp_cal_1");
      csr_check(thc_pkg::REG_TEMP_CAL_2,       16, 32'(c.temp_cal_2),       "temp_cal_2");
      csr_check(thc_pkg::REG_TEMP_CAL_3,       16, 32'(c.temp_cal_3),       "temp_cal_3");
      csr_check(thc_pkg::REG_HUM_CAL_1,         8, 32'(c.hum_cal_1),        "hum_cal_1");
      csr_check(thc_pkg::REG_HUM_CAL_2,        16, 32'(c.hum_cal_2),        "hum_cal_2");
      csr_check(thc_pkg::REG_HUM_CAL_3,         8, 32'(c.hum_cal_3),        "hum_cal_3");
      csr_check(thc_pkg::REG_HUM_CAL_45_BYTES, 24, 32'(c.hum_cal_45_bytes),
                "hum_cal_45_bytes");
      csr_check(thc_pkg::REG_HUM_CAL_6,         8, 32'(c.hum_cal_6),        "hum_cal_6");
      sb.cal = c;
   endtask

   function automatic thc_tb_pkg::thc_cal_type random_cal();
      thc_tb_pkg::thc_cal_type c;
      c.temp_cal_1       = 16'($urandom);
      c.temp_cal_2       = 16'($urandom);
      c.temp_cal_3       = 16'($urandom);
      c.hum_cal_1        = 8'($urandom);
      c.hum_cal_2        = 16'($urandom);
      c.hum_cal_3        = 8'($urandom);
      c.hum_cal_45_bytes = 24'($urandom);
      c.hum_cal_6        = 8'($urandom);
      return c;
   endfunction

   initial begin
      thc_tb_pkg::thc_cal_type plan [PHASES];
      bit [19:0]  temp_raw;
      bit [15:0]  hum_raw;
      int         offs;
      int         n_rand;
      int         ph;
      int         k;

      // every input known from time zero
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      n_rand      = 0;

      // typical factory calibration, word four 313 and word five 50 packed as bytes
      plan[0] = '{temp_cal_1: 16'd27504, temp_cal_2: 16'd26435, temp_cal_3: -16'sd1000,
                  hum_cal_1: 8'd75, hum_cal_2: 16'd362, hum_cal_3: 8'd0,
                  hum_cal_45_bytes: 24'h032913, hum_cal_6: 8'd30};
      // all zero
      plan[1] = '0;
      // every word at its top value, but words four and five are all ones (-1)
      plan[2] = '{temp_cal_1: 16'hFFFF, temp_cal_2: 16'h7FFF, temp_cal_3: 16'h7FFF,
                  hum_cal_1: 8'hFF, hum_cal_2: 16'h7FFF, hum_cal_3: 8'hFF,
                  hum_cal_45_bytes: 24'hFFFFFF, hum_cal_6: 8'h7F};
      // signed words at their most negative, words four and five at -2048
      plan[3] = '{temp_cal_1: 16'h0000, temp_cal_2: 16'h8000, temp_cal_3: 16'h8000,
                  hum_cal_1: 8'h00, hum_cal_2: 16'h8000, hum_cal_3: 8'h00,
                  hum_cal_45_bytes: 24'h800080, hum_cal_6: 8'h80};
      // a second plausible part, word four 339 and word five 0
      plan[4] = '{temp_cal_1: 16'd28009, temp_cal_2: 16'd25654, temp_cal_3: 16'd50,
                  hum_cal_1: 8'd75, hum_cal_2: 16'd352, hum_cal_3: 8'd0,
                  hum_cal_45_bytes: 24'h000315, hum_cal_6: 8'd30};
      plan[5] = random_cal();
      plan[6] = random_cal();

      // synchronous reset, released at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers must come out of reset cleared
      csr_check(thc_pkg::REG_TEMP_CAL_1,       16, 32'd0, "temp_cal_1");
      csr_check(thc_pkg::REG_TEMP_CAL_2,       16, 32'd0, "temp_cal_2");
      csr_check(thc_pkg::REG_TEMP_CAL_3,       16, 32'd0, "temp_cal_3");
      csr_check(thc_pkg::REG_HUM_CAL_1,         8, 32'd0, "hum_cal_1");
      csr_check(thc_pkg::REG_HUM_CAL_2,        16, 32'd0, "hum_cal_2");
      csr_check(thc_pkg::REG_HUM_CAL_3,         8, 32'd0, "hum_cal_3");
      csr_check(thc_pkg::REG_HUM_CAL_45_BYTES, 24, 32'd0, "hum_cal_45_bytes");
      csr_check(thc_pkg::REG_HUM_CAL_6,         8, 32'd0, "hum_cal_6");

      for (ph = 0; ph < PHASES; ph++) begin
         // calibration changes only with the pipe empty
         drain();
         apply_cal(plan[ph]);

         if (ph == 0) begin
            // typical part: cold and hot saturation, humidity clamps at both ends,
            // fine temperature near zero, and alternating bit patterns
            send_sample(20'd440064, 16'd0);
            send_sample(20'd440064, 16'hFFFF);
            send_sample(20'd519888, 16'd30000);
            send_sample(20'd519888, 16'h8000);
            send_sample(20'hAAAAA, 16'hAAAA);
            send_sample(20'h55555, 16'h5555);
            send_sample(20'd600000, 16'd25000);
            send_sample(20'd480000, 16'd40000);
            send_sample(20'd380000, 16'd20000);
            send_sample(20'd200000, 16'd30000);
            send_sample(20'd900000, 16'd30000);
         end

         // field corners under every calibration set
         send_sample(20'd0,     16'd0);
         send_sample(20'hFFFFF, 16'hFFFF);
         send_sample(20'd0,     16'hFFFF);
         send_sample(20'hFFFFF, 16'd0);

         for (k = 0; k < RAND_ITEMS; k++) begin
            // first a slow receiver, then a slow sender, then full rate
            if (n_rand < TOTAL_RAND / 3) begin
               send_idle_pct = 11;
               stall_pct     = 54;
            end else if (n_rand < 2 * TOTAL_RAND / 3) begin
               send_idle_pct = 54;
               stall_pct     = 11;
            end else begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end

            // sender holds off mid-phase until the pipe has emptied
            if (k == RAND_ITEMS / 2) drain();

            // mostly readings around the calibrated operating range, the rest anywhere
            if ($urandom_range(3) == 0) begin
               temp_raw = 20'($urandom);
               hum_raw  = 16'($urandom);
            end else begin
               offs     = int'($urandom_range(700000)) - 250000;
               temp_raw = 20'(int'(sb.cal.temp_cal_1) * 16 + offs);
               hum_raw  = ($urandom_range(1) == 0) ? 16'($urandom) :
                                                     16'($urandom_range(50000, 15000));
            end
            send_sample(temp_raw, hum_raw);
            n_rand++;
         end
      end

      // all stimulus in: wait for the last results, then let the pipe settle
      drain();
      repeat (thc_pkg::STAGES + 4) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("temp_humidity_compensation verification clean");
      end else begin
         $display("temp_humidity_compensation verification failed");
      end
      $finish;
   end

endmodule
